// File: rtl/core/history_ring_with_delete_assert.svh
// ----------------------------------------------------------------------------
// History ring assertion macros
// Property templates used by the history ring datapath.
// ----------------------------------------------------------------------------
`ifndef HISTORY_RING_WITH_DELETE_ASSERT_SVH
`define HISTORY_RING_WITH_DELETE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define HRD_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/hrd_pkg.sv
// ----------------------------------------------------------------------------
// hrd_pkg
// Operation codes and controller/datapath interface types of the history ring.
// ----------------------------------------------------------------------------
package hrd_pkg;

   // ring depth is fixed: position and count widths below are sized for it
   localparam int DEPTH   = 16;
   localparam int KIND_W  = 2;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 2'd0,
      KIND_READ   = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_CLEAR  = 2'd3
   } hrd_kind_type;

   // Commands from the controller to the datapath (finish also loads the output stage)
   typedef struct packed {
      logic load;
      logic push;
      logic clear;
      logic mark_bad;
      logic walk_start;
      logic walk_step;
      logic read_hit;
      logic del_hit;
      logic del_start;
      logic fetch_next;
      logic sh_step;
      logic fetch_ahead;
      logic del_end;
      logic finish;
   } hrd_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      hrd_kind_type kind;
      logic         pos_ok;
      logic         slot_valid;
      logic         seen_hit;
      logic         more;
      logic         more_next;
   } hrd_status_type;

endpackage

// File: rtl/core/hrd_ctrl.sv
// ----------------------------------------------------------------------------
// hrd_ctrl
// Sequencer of the history ring: decode, slot walk, shift-down and finish.
// ----------------------------------------------------------------------------
module hrd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    out_free,
   input  hrd_pkg::hrd_status_type status,
   output logic                    req_ready,
   output hrd_pkg::hrd_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_DECODE    = 7'b0000010,
      ST_WALK      = 7'b0000100,
      ST_DEL_START = 7'b0001000,
      ST_SH_WR     = 7'b0010000,
      ST_DEL_END   = 7'b0100000,
      ST_FIN       = 7'b1000000
   } hrd_state_type;

   hrd_state_type state_ff;
   hrd_state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.kind)
               hrd_pkg::KIND_PUSH: begin
                  cmd.push = 1'b1;
                  state_in = ST_FIN;
               end
               hrd_pkg::KIND_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_FIN;
               end
               hrd_pkg::KIND_READ, hrd_pkg::KIND_DELETE: begin
                  if (status.pos_ok) begin
                     cmd.walk_start = 1'b1;
                     state_in       = ST_WALK;
                  end else begin
                     cmd.mark_bad = 1'b1;
                     state_in     = ST_FIN;
                  end
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_WALK: begin
            // stop on the target valid slot, else advance one slot
            if (status.slot_valid && status.seen_hit) begin
               if (status.kind == hrd_pkg::KIND_READ) begin
                  cmd.read_hit = 1'b1;
                  state_in     = ST_FIN;
               end else begin
                  cmd.del_hit = 1'b1;
                  state_in    = ST_DEL_START;
               end
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_DEL_START: begin
            cmd.del_start = 1'b1;
            if (status.more) begin
               cmd.fetch_next = 1'b1;
               state_in       = ST_SH_WR;
            end else begin
               state_in = ST_DEL_END;
            end
         end
         ST_SH_WR: begin
            cmd.sh_step = 1'b1;
            if (status.more_next) begin
               cmd.fetch_ahead = 1'b1;
            end else begin
               state_in = ST_DEL_END;
            end
         end
         ST_DEL_END: begin
            cmd.del_end = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/hrd_dpath.sv
// ----------------------------------------------------------------------------
// hrd_dpath
// Slot store, valid bits, write pointer, valid count and walk/shift indexes.
// ----------------------------------------------------------------------------
`include "history_ring_with_delete_assert.svh"

module hrd_dpath #(
   parameter int DATA_W = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hrd_pkg::hrd_cmd_type         cmd,
   input  logic [hrd_pkg::KIND_W-1:0]   req_kind,
   input  logic [hrd_pkg::POS_W-1:0]    req_pos,
   input  logic [DATA_W-1:0]            req_data,
   output hrd_pkg::hrd_status_type      status,
   output logic [DATA_W-1:0]            res_data,
   output logic                         res_found,
   output logic                         res_bad,
   output logic [hrd_pkg::COUNT_W-1:0]  res_count
);

   localparam int DEPTH = hrd_pkg::DEPTH;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > hrd_pkg::POS_W) ? CNT_W : hrd_pkg::POS_W) + 1;
   localparam int SUM_W = ((IDX_W > hrd_pkg::POS_W) ? IDX_W : hrd_pkg::POS_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   hrd_pkg::hrd_kind_type       kind_ff, kind_in;
   logic [hrd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [DATA_W-1:0]           wdata_ff, wdata_in;
   logic [IDX_W-1:0]            wp_ff, wp_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]            seen_ff, seen_in;
   logic [CNT_W-1:0]            k_ff, k_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        drop_ff, drop_in;
   logic                        found_ff, found_in;
   logic                        bad_ff, bad_in;
   logic [DEPTH-1:0]            valid_ff, valid_in;
   logic [DATA_W-1:0]           slot_mem_ff [DEPTH];
   logic [DATA_W-1:0]           rdata_ff;

   logic [IDX_W-1:0]            nx, nx2, start_idx;
   logic [SUM_W-1:0]            start_sum, start_wrap;
   logic [CMP_W-1:0]            pos_c, cnt_c, k_c;
   logic [CNT_W-1:0]            target;
   logic                        mem_we, mem_re;
   logic [IDX_W-1:0]            mem_waddr, mem_raddr;
   logic [DATA_W-1:0]           mem_wdata;
   logic [CNT_W+hrd_pkg::COUNT_W-1:0] count_wide;

   assign nx  = next_idx(idx_ff);
   assign nx2 = next_idx(nx);

   assign pos_c = CMP_W'(pos_ff);
   assign cnt_c = CMP_W'(count_ff);
   assign k_c   = CMP_W'(k_ff);

   // delete starts pos physical slots after the oldest valid slot
   assign start_sum  = SUM_W'(idx_ff) + SUM_W'(pos_ff);
   assign start_wrap = (start_sum >= SUM_W'(DEPTH)) ? start_sum - SUM_W'(DEPTH) : start_sum;
   assign start_idx  = start_wrap[IDX_W-1:0];

   assign target = (kind_ff == hrd_pkg::KIND_READ) ? CNT_W'(pos_ff) : '0;

   assign status.kind       = kind_ff;
   assign status.pos_ok     = pos_c < cnt_c;
   assign status.slot_valid = valid_ff[idx_ff];
   assign status.seen_hit   = seen_ff == target;
   assign status.more       = (k_c + CMP_W'(1)) < cnt_c;
   assign status.more_next  = (k_c + CMP_W'(2)) < cnt_c;

   always_comb begin
      kind_in  = kind_ff;
      pos_in   = pos_ff;
      wdata_in = wdata_ff;
      wp_in    = wp_ff;
      idx_in   = idx_ff;
      seen_in  = seen_ff;
      k_in     = k_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      found_in = found_ff;
      bad_in   = bad_ff;
      valid_in = valid_ff;

      if (cmd.load) begin
         kind_in  = hrd_pkg::hrd_kind_type'(req_kind);
         pos_in   = req_pos;
         wdata_in = req_data;
         found_in = 1'b0;
         bad_in   = 1'b0;
      end
      if (cmd.mark_bad) begin
         bad_in = 1'b1;
      end
      if (cmd.walk_start) begin
         idx_in  = wp_ff;
         seen_in = '0;
      end
      if (cmd.walk_step) begin
         idx_in  = nx;
         seen_in = seen_ff + CNT_W'(valid_ff[idx_ff]);
      end
      if (cmd.read_hit) begin
         found_in = 1'b1;
      end
      if (cmd.del_hit) begin
         idx_in = start_idx;
         k_in   = CNT_W'(pos_ff);
      end
      if (cmd.del_start) begin
         // the valid bit at the start slot is the one the shift drops
         drop_in = valid_ff[idx_ff];
      end
      if (cmd.sh_step) begin
         valid_in[idx_ff] = valid_ff[nx];
         idx_in           = nx;
         k_in             = k_ff + 1'b1;
      end
      if (cmd.push) begin
         valid_in[wp_ff] = 1'b1;
         wp_in           = next_idx(wp_ff);
         count_in        = count_ff + CNT_W'(!valid_ff[wp_ff]);
      end
      if (cmd.del_end) begin
         valid_in[idx_ff] = 1'b0;
         wp_in            = (wp_ff == '0) ? LAST_IDX : wp_ff - 1'b1;
         count_in         = count_ff - CNT_W'(drop_ff);
      end
      if (cmd.clear) begin
         valid_in = '0;
         wp_in    = '0;
         count_in = '0;
      end
   end

   assign mem_we    = cmd.push || cmd.sh_step;
   assign mem_waddr = cmd.push ? wp_ff : idx_ff;
   assign mem_wdata = cmd.push ? wdata_ff : rdata_ff;

   // read one slot ahead of the shift write so the next entry is already fetched when it is written
   assign mem_re = cmd.read_hit || cmd.fetch_next || cmd.fetch_ahead;
   always_comb begin
      priority if (cmd.read_hit) begin
         mem_raddr = idx_ff;
      end else if (cmd.fetch_next) begin
         mem_raddr = nx;
      end else begin
         mem_raddr = nx2;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= slot_mem_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         count_ff <= '0;
         valid_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      pos_ff   <= pos_in;
      wdata_ff <= wdata_in;
      idx_ff   <= idx_in;
      seen_ff  <= seen_in;
      k_ff     <= k_in;
      drop_ff  <= drop_in;
      found_ff <= found_in;
      bad_ff   <= bad_in;
   end

   assign count_wide = (CNT_W + hrd_pkg::COUNT_W)'(count_ff);

   assign res_data  = found_ff ? rdata_ff : '0;
   assign res_found = found_ff;
   assign res_bad   = bad_ff;
   assign res_count = count_wide[hrd_pkg::COUNT_W-1:0];

   `HRD_ASSERT(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "valid count above depth")
   `HRD_ASSERT_NEXT(a_clear_empty, clock, reset, cmd.clear, (count_ff == '0) && (valid_ff == '0), "store not empty after clear")
   `HRD_ASSERT_NEXT(a_push_fresh, clock, reset, cmd.push && !valid_ff[wp_ff], count_ff == $past(count_ff) + 1'b1, "push into free slot did not grow count")

endmodule

// File: rtl/core/history_ring_with_delete.sv
// ----------------------------------------------------------------------------
// history_ring_with_delete
// History ring of DEPTH data words with push, read, delete and clear.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. Push, clear and a read or delete at a
// position not below the stored count return their response beat without a
// slot walk. A read walks the ring one slot per cycle from the write pointer
// until it reaches the requested valid entry. A delete walks to the oldest
// valid slot the same way, then shifts the later entries down one slot per
// cycle through the single-write, registered-read slot memory, moving at most
// DEPTH - 1 entries. A new request is taken while the previous response still
// waits in the output register. The response carries the valid count after
// the operation and flags a position outside the stored entries as bad_index.
// ----------------------------------------------------------------------------
module history_ring_with_delete #(
   parameter int  DATA_W = 32,
   localparam int REQ_W  = ((hrd_pkg::POS_W + DATA_W + 7) / 8) * 8,
   localparam int RSP_W  = ((DATA_W + hrd_pkg::COUNT_W + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_W-1:0]           req_tdata,   // position, entry_data_in
   input  logic [hrd_pkg::KIND_W-1:0] req_tuser,   // kind
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_W-1:0]           rsp_tdata,   // entry_data, stored_count
   output logic [1:0]                 rsp_tuser    // entry_found, bad_index
);

   hrd_pkg::hrd_cmd_type    cmd;
   hrd_pkg::hrd_status_type status;

   logic                        out_free;
   logic [DATA_W-1:0]           res_data;
   logic                        res_found;
   logic                        res_bad;
   logic [hrd_pkg::COUNT_W-1:0] res_count;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]           rsp_data_ff;
   logic                        rsp_found_ff;
   logic                        rsp_bad_ff;
   logic [hrd_pkg::COUNT_W-1:0] rsp_count_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   hrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   hrd_dpath #(
      .DATA_W (DATA_W)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_kind  (req_tuser),
      .req_pos   (req_tdata[hrd_pkg::POS_W-1:0]),
      .req_data  (req_tdata[hrd_pkg::POS_W +: DATA_W]),
      .status    (status),
      .res_data  (res_data),
      .res_found (res_found),
      .res_bad   (res_bad),
      .res_count (res_count)
   );

   // hold the response beat until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff  <= res_data;
         rsp_found_ff <= res_found;
         rsp_bad_ff   <= res_bad;
         rsp_count_ff <= res_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_data_ff});
   assign rsp_tuser  = {rsp_bad_ff, rsp_found_ff};

endmodule
